// File: rtl/ssid_pkg.sv
// Shared types and constants for the sorted set insert/delete unit.
`default_nettype none

package ssid_pkg;

   localparam int SSID_CAPACITY = 64;
   localparam int VALUE_W       = 32;
   localparam int OCC_W         = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LIST   = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4,
      ST_ELEMENT   = 3'd5,
      ST_EMPTY     = 3'd6
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       capture;     // latch the request value, restart the list cursor
      logic       compare;     // register the per-entry less/equal flags
      logic       commit_ins;  // open a slot and write the value
      logic       commit_del;  // close the matching slot
      logic       rotate;      // rotate held entries down by one (list walk)
      logic       load_rsp;    // load the response word
      status_type rsp_status;
      logic       rsp_elem;    // response carries the head entry
      logic       rsp_last;
   } ssid_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic dup;        // value is held
      logic full;
      logic empty;
      logic list_last;  // cursor sits on the last held entry
   } ssid_stat_type;

endpackage

`default_nettype wire

// File: rtl/ssid_store.sv
// Datapath: shift-array entry store, compare row, counters and response word.
`default_nettype none

module ssid_store
   import ssid_pkg::*;
#(
   parameter int CAPACITY = SSID_CAPACITY
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   input  wire ssid_cmd_type               cmd,
   output ssid_stat_type                   stat,
   output logic [2:0]                      rsp_status,
   output logic signed [VALUE_W-1:0]       rsp_element,
   output logic [OCC_W-1:0]                rsp_occupancy,
   output logic                            rsp_last
);

   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W = IDX_W + 1;

   logic signed [VALUE_W-1:0] entries_ff [CAPACITY];
   logic signed [VALUE_W-1:0] entries_in [CAPACITY];
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [VALUE_W-1:0] value_ff;
   logic [CAPACITY-1:0]       lt_ff, lt_in;
   logic [CAPACITY-1:0]       eq_ff, eq_in;
   logic [IDX_W-1:0]          list_idx_ff, list_idx_in;

   logic [2:0]                rsp_status_ff;
   logic signed [VALUE_W-1:0] rsp_element_ff, rsp_element_in;
   logic [OCC_W-1:0]          rsp_occupancy_ff;
   logic                      rsp_last_ff;

   // Per-entry cell: compare against the request and choose the next entry value.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int PREV = (i == 0) ? 0 : i - 1;
      localparam int NEXT = (i == CAPACITY - 1) ? i : i + 1;
      logic held;
      logic lt_prev;

      assign held    = COUNT_W'(i) < count_ff;
      assign lt_prev = (i == 0) ? 1'b1 : lt_ff[PREV];
      assign lt_in[i] = held && (entries_ff[i] < value_ff);
      assign eq_in[i] = held && (entries_ff[i] == value_ff);

      always_comb begin
         entries_in[i] = entries_ff[i];
         if (cmd.commit_ins && !lt_ff[i]) begin
            // first slot not below the value takes it, the rest move up
            entries_in[i] = lt_prev ? value_ff : entries_ff[PREV];
         end else if (cmd.commit_del && !lt_ff[i] && (i != CAPACITY - 1)) begin
            entries_in[i] = entries_ff[NEXT];
         end else if (cmd.rotate && held) begin
            entries_in[i] = (COUNT_W'(i + 1) == count_ff) ? entries_ff[0]
                                                           : entries_ff[NEXT];
         end
      end

      always_ff @(posedge clock) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit_ins) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.commit_del) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   assign list_idx_in    = cmd.capture ? '0
                         : (cmd.rotate ? list_idx_ff + IDX_W'(1) : list_idx_ff);
   assign rsp_element_in = cmd.rsp_elem ? entries_ff[0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff <= req_value;
      end
      if (cmd.compare) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      list_idx_ff <= list_idx_in;
      if (cmd.load_rsp) begin
         rsp_status_ff    <= cmd.rsp_status;
         rsp_element_ff   <= rsp_element_in;
         rsp_occupancy_ff <= OCC_W'(count_in);
         rsp_last_ff      <= cmd.rsp_last;
      end
   end

   assign stat.dup       = |eq_ff;
   assign stat.full      = count_ff == COUNT_W'(CAPACITY);
   assign stat.empty     = count_ff == '0;
   assign stat.list_last = (COUNT_W'(list_idx_ff) + COUNT_W'(1)) == count_ff;

   assign rsp_status    = rsp_status_ff;
   assign rsp_element   = rsp_element_ff;
   assign rsp_occupancy = rsp_occupancy_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_ins_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_ins |-> !stat.full && !stat.dup)
      else $error("insert committed into full set or on a duplicate");

   a_del_single_match: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_del |-> $onehot(eq_ff))
      else $error("delete committed without exactly one match");

   a_del_count: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_del |=> count_ff == $past(count_ff) - COUNT_W'(1))
      else $error("delete did not drop the count by one");
`endif

endmodule

`default_nettype wire

// File: rtl/ssid_ctrl.sv
// Controller: request sequencing and response word valid.
`default_nettype none

module ssid_ctrl
   import ssid_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_opcode,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire ssid_stat_type stat,
   output ssid_cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE,
      S_LIST
   } state_type;

   state_type  state_ff, state_in;
   opcode_type op_ff, op_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      cmd            = '0;
      cmd.rsp_status = ST_INSERTED;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = opcode_type'(req_opcode);
               case (opcode_type'(req_opcode))
                  OP_INSERT, OP_DELETE: state_in = S_COMPARE;
                  OP_LIST:              state_in = S_LIST;
                  default:              state_in = S_IDLE;  // drop unused code
               endcase
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_last = 1'b1;
               state_in     = S_IDLE;
               if (op_ff == OP_INSERT) begin
                  if (stat.dup) begin
                     cmd.rsp_status = ST_DUPLICATE;
                  end else if (stat.full) begin
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.rsp_status = ST_INSERTED;
                     cmd.commit_ins = 1'b1;
                  end
               end else if (stat.dup) begin
                  cmd.rsp_status = ST_REMOVED;
                  cmd.commit_del = 1'b1;
               end else begin
                  cmd.rsp_status = ST_NOT_FOUND;
               end
            end
         end
         S_LIST: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               if (stat.empty) begin
                  cmd.rsp_status = ST_EMPTY;
                  cmd.rsp_last   = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cmd.rsp_status = ST_ELEMENT;
                  cmd.rsp_elem   = 1'b1;
                  cmd.rotate     = 1'b1;
                  cmd.rsp_last   = stat.list_last;
                  if (stat.list_last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/sorted_set_insert_delete_unit.sv
// Top level of the sorted set insert/delete unit.
`default_nettype none

// Holds up to CAPACITY signed 32-bit values in ascending order in a
// shift-array store (one register row, one comparator per entry). One word
// is handled at a time: req_stall is high from the cycle after a word is
// accepted until its last response word is loaded into the output register.
// Insert and delete pass through accept, a compare pass over all entries at
// once, and an update that opens or closes one slot by shifting the row
// while the single status word is loaded. A list word is accepted and then
// sends one response word per held value (a single status word for an empty
// set): the row rotates down by one position per response word, so the head
// entry is always the one sent, and after the walk the row is back in order.
// The output register lets the unit accept the next word and run its
// compare pass while the previous response still waits; a stalled response
// holds the unit in whichever step would load its next response word. An
// unused opcode is accepted and dropped with no response. Entry
// registers are not cleared by reset; only entries below the count ever
// reach a response or a compare flag.
module sorted_set_insert_delete_unit
   import ssid_pkg::*;
#(
   parameter int CAPACITY = SSID_CAPACITY
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_opcode,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [2:0]                     rsp_status,
   output logic signed [VALUE_W-1:0]      rsp_element,
   output logic [OCC_W-1:0]               rsp_occupancy,
   output logic                           rsp_last
);

   ssid_cmd_type  cmd;
   ssid_stat_type stat;

   // Sequence each word and own the response valid.
   ssid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Hold the entries, the count and the response payload.
   ssid_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_status),
      .rsp_element   (rsp_element),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire
